FILE: src/lru_key_handle_cache_macros.svh
// ----------------------------------------------------------------------------
// lru_key_handle_cache_macros.svh
// Assertion shorthands used by the checker file of the LRU key cache.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_HANDLE_CACHE_MACROS_SVH
`define LRU_KEY_HANDLE_CACHE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define LKH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define LKH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lkh_pkg.sv
// ----------------------------------------------------------------------------
// lkh_pkg
// Shared constants and helpers of the LRU key/handle cache.
// ----------------------------------------------------------------------------
package lkh_pkg;

    localparam int KEY_W = 32;

    // Item kind carried on tuser
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    // Round a bit count up to whole bytes
    function automatic int pad_bytes(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

FILE: src/lkh_ram.sv
// ----------------------------------------------------------------------------
// lkh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lkh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lkh_ring.sv
// ----------------------------------------------------------------------------
// lkh_ring
// Ring address unit: maps a list rank onto a physical RAM slot.
// ----------------------------------------------------------------------------
module lkh_ring #(
    parameter int DEPTH = 32
) (
    input  logic [$clog2(DEPTH)-1:0] i_base,
    input  logic [$clog2(DEPTH)-1:0] i_ofs,
    output logic [$clog2(DEPTH)-1:0] o_addr
);

    localparam int AW = $clog2(DEPTH);

    logic [AW:0] sum;
    logic [AW:0] wrap;

    // Both operands stay below DEPTH, so one conditional subtract is enough
    always_comb begin
        sum    = {1'b0, i_base} + {1'b0, i_ofs};
        wrap   = sum - (AW+1)'(DEPTH);
        o_addr = (sum >= (AW+1)'(DEPTH)) ? wrap[AW-1:0] : sum[AW-1:0];
    end

endmodule

FILE: src/lru_key_handle_cache.sv
// ----------------------------------------------------------------------------
// lru_key_handle_cache
// Move-to-front LRU list of key/handle pairs with lookup-promote and insert.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake              Payload
//  s (item)  in   i_s_tvalid/o_s_tready  tuser: kind; tdata: key, new_handle
//  m (res)   out  o_m_tvalid/i_m_tready  tdata: hit, handle, evicted,
//                                        evicted_handle, occupancy
//
//  Scan: a lookup walks the list through the single RAM read port, one
//  entry per cycle, while the shared key comparator checks each one; a
//  lookup on an empty list skips the scan.
//  Reset: i_rst_n low clears the list (count and ring base), no sweep.
//  Stalls: the result sits in an output register; while it is not taken,
//  one more item is still accepted, but its result waits and blocks the next.
//
// The list is kept as a ring in one RAM. Rank r lives at slot base+r.
// A lookup scans from the front and, speculatively, writes each entry one
// rank further back as it goes. On a hit the found entry is then written to
// the front; on a miss the whole list has moved back by one, so the last
// entry is written behind it and the base advances, which restores order.
// An insert steps the base back by one and writes the new pair there; when
// the list is full, that slot held the least recent entry, which is read
// first and reported as evicted.
// ----------------------------------------------------------------------------
module lru_key_handle_cache
    import lkh_pkg::*;
#(
    parameter int CACHE_DEPTH = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // item channel
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tdata: key [31:0], new_handle [KEY_W +: HANDLE_BITS], zero pad
    input  logic [pad_bytes(KEY_W+HANDLE_BITS)-1:0] i_s_tdata,
    // tuser: kind (0 lookup, 1 insert)
    input  logic i_s_tuser,
    // result channel
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // tdata: hit, handle, evicted, evicted_handle, occupancy, zero pad
    output logic [pad_bytes(2*HANDLE_BITS+2+$clog2(CACHE_DEPTH+1))-1:0] o_m_tdata
);

    localparam int AW    = $clog2(CACHE_DEPTH);
    localparam int CW    = $clog2(CACHE_DEPTH+1);
    localparam int EW    = KEY_W + HANDLE_BITS;
    localparam int OUT_W = pad_bytes(2*HANDLE_BITS+2+CW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FRONT,
        S_TAIL,
        S_INS_RD,
        S_INS_WR,
        S_RESP
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_base;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_k;
    logic [KEY_W-1:0]       r_key;
    logic [HANDLE_BITS-1:0] r_nh;
    logic [EW-1:0]          r_prev;
    logic                   r_hit;
    logic [HANDLE_BITS-1:0] r_hit_h;
    logic                   r_ev;
    logic [HANDLE_BITS-1:0] r_ev_h;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;

    logic [EW-1:0]          rdata;
    logic [KEY_W-1:0]       rd_key;
    logic [HANDLE_BITS-1:0] rd_h;
    logic                   match;
    logic                   last;
    logic                   full;
    logic [AW-1:0]          n_rel;
    logic [AW-1:0]          base_dec;
    logic [AW-1:0]          base_inc;
    logic [AW-1:0]          rd_ofs;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_ofs;
    logic [AW-1:0]          wr_addr;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [EW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;

    assign rd_key   = rdata[EW-1:HANDLE_BITS];
    assign rd_h     = rdata[HANDLE_BITS-1:0];
    assign match    = (rd_key == r_key);
    assign last     = ((CW'(r_k) + CW'(1)) == r_count);
    assign full     = (r_count == CW'(CACHE_DEPTH));
    // Rank just behind the list; wraps onto the base when full
    assign n_rel    = full ? '0 : r_count[AW-1:0];
    assign base_dec = (r_base == '0) ? AW'(CACHE_DEPTH-1) : r_base - AW'(1);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Read side: prefetch the next rank while the current one is compared
    assign rd_ofs    = ((r_state == S_SCAN) && !last) ? r_k + AW'(1) : '0;
    assign ram_raddr = (r_state == S_INS_RD) ? base_dec : rd_addr;

    always_comb begin
        ram_we    = 1'b0;
        wr_ofs    = '0;
        ram_wdata = r_prev;
        unique case (r_state)
            S_SCAN: begin
                // Push the previous entry one rank back
                ram_we = (r_k != '0);
                wr_ofs = r_k;
            end
            S_FRONT: begin
                ram_we    = 1'b1;
                ram_wdata = {r_key, r_hit_h};
            end
            S_TAIL: begin
                ram_we = 1'b1;
                wr_ofs = n_rel;
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_wdata = {r_key, r_nh};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_waddr = (r_state == S_INS_WR) ? base_dec : wr_addr;

    lkh_ring #(.DEPTH(CACHE_DEPTH)) u_ring_rd (
        .i_base (r_base),
        .i_ofs  (rd_ofs),
        .o_addr (rd_addr)
    );

    lkh_ring #(.DEPTH(CACHE_DEPTH)) u_ring_wr (
        .i_base (r_base),
        .i_ofs  (wr_ofs),
        .o_addr (wr_addr)
    );

    lkh_ring #(.DEPTH(CACHE_DEPTH)) u_ring_inc (
        .i_base (r_base),
        .i_ofs  (AW'(1)),
        .o_addr (base_inc)
    );

    lkh_ram #(.WIDTH(EW), .DEPTH(CACHE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result beat once taken; the response state reloads it
            if (r_out_valid && i_m_tready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_key   <= i_s_tdata[KEY_W-1:0];
                        r_nh    <= i_s_tdata[KEY_W +: HANDLE_BITS];
                        r_hit   <= 1'b0;
                        r_hit_h <= '0;
                        r_ev    <= 1'b0;
                        r_ev_h  <= '0;
                        r_k     <= '0;
                        if (i_s_tuser == KIND_INSERT) begin
                            r_state <= S_INS_RD;
                        end else if (r_count == '0) begin
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        r_hit   <= 1'b1;
                        r_hit_h <= rd_h;
                        // Already at the front: nothing moved
                        r_state <= (r_k == '0) ? S_RESP : S_FRONT;
                    end else begin
                        r_prev <= rdata;
                        if (last) begin
                            r_state <= S_TAIL;
                        end else begin
                            r_k <= r_k + AW'(1);
                        end
                    end
                end
                S_FRONT: begin
                    r_state <= S_RESP;
                end
                S_TAIL: begin
                    // Whole list slid back by one: advance base to undo it
                    r_base  <= base_inc;
                    r_state <= S_RESP;
                end
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    if (full) begin
                        r_ev   <= 1'b1;
                        r_ev_h <= rd_h;
                    end else begin
                        r_count <= r_count + CW'(1);
                    end
                    r_base  <= base_dec;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= OUT_W'({r_count, r_ev_h, r_ev, r_hit_h, r_hit});
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/lkh_checker.sv
// ----------------------------------------------------------------------------
// lkh_checker
// Port-level checks of the LRU key/handle cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_key_handle_cache_macros.svh"

module lkh_checker
    import lkh_pkg::*;
#(
    parameter int CACHE_DEPTH = 32,
    parameter int HANDLE_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [pad_bytes(2*HANDLE_BITS+2+$clog2(CACHE_DEPTH+1))-1:0] o_m_tdata
);

    localparam int CW = $clog2(CACHE_DEPTH+1);

    logic                   hit;
    logic [HANDLE_BITS-1:0] handle;
    logic                   evicted;
    logic [CW-1:0]          occ;

    assign hit     = o_m_tdata[0];
    assign handle  = o_m_tdata[1 +: HANDLE_BITS];
    assign evicted = o_m_tdata[HANDLE_BITS+1];
    assign occ     = o_m_tdata[2*HANDLE_BITS+2 +: CW];

    `LKH_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")
    `LKH_ASSERT_NXT(a_busy_after_accept, i_s_tvalid && o_s_tready,
        !o_s_tready, "item accepted while previous item in progress")
    `LKH_ASSERT_IMP(a_hit_no_evict, o_m_tvalid, !(hit && evicted),
        "hit and eviction reported on one result")
    `LKH_ASSERT_IMP(a_miss_handle_zero, o_m_tvalid && !hit, handle == '0,
        "nonzero handle on a miss")
    `LKH_ASSERT_IMP(a_occ_range, o_m_tvalid, occ <= CW'(CACHE_DEPTH),
        "occupancy above list depth")

endmodule

bind lru_key_handle_cache lkh_checker #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
) u_lkh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
